[src/key_matrix_scan_debounce_defines.svh]
// Assertion macros for the key matrix scan and debounce block.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_DEFINES_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define KMSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key matrix scan check failed");

// Consequent must hold in the cycle after the antecedent
`define KMSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key matrix scan check failed");

`endif

[src/kmsd_pkg.sv]
// Shared types, constants and the column drive table for the key matrix scanner.
// No dependencies.
package kmsd_pkg;

    localparam int ROWS_DEFAULT  = 8;
    localparam int COLS_DEFAULT  = 18;
    localparam int DRIVE_ENTRIES = 18;
    localparam int SETTLE_W      = 8;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd5;

    typedef enum logic {
        OP_SAMPLE   = 1'b0,
        OP_END_SCAN = 1'b1
    } op_t;

    // One input item as held in the input register
    typedef struct packed {
        op_t        op;
        logic [4:0] column;
        logic [7:0] row_bits;
        logic [2:0] query_row;
        logic [4:0] query_column;
    } item_t;

    // One result item
    typedef struct packed {
        logic        settled;
        logic [17:0] stable_row;
        logic        key_is_on;
        logic [7:0]  key_count;
        logic [6:0]  column_drive;
    } result_t;

    // Select port pattern for each column of the demultiplexer
    function automatic logic [6:0] drive_pattern(input logic [4:0] col);
        logic [6:0] pat;
        case (col)
            5'd0:    pat = 7'h64;
            5'd1:    pat = 7'h54;
            5'd2:    pat = 7'h44;
            5'd3:    pat = 7'h17;
            5'd4:    pat = 7'h07;
            5'd5:    pat = 7'h73;
            5'd6:    pat = 7'h63;
            5'd7:    pat = 7'h53;
            5'd8:    pat = 7'h43;
            5'd9:    pat = 7'h33;
            5'd10:   pat = 7'h23;
            5'd11:   pat = 7'h13;
            5'd12:   pat = 7'h03;
            5'd13:   pat = 7'h56;
            5'd14:   pat = 7'h46;
            5'd15:   pat = 7'h75;
            5'd16:   pat = 7'h45;
            5'd17:   pat = 7'h74;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

[src/kmsd_in_stage.sv]
// Input register stage: captures one item and holds it until the core takes it.
// Depends on kmsd_pkg.
module kmsd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  kmsd_pkg::item_t item_in,
    output kmsd_pkg::item_t item_out,
    output logic           item_valid,
    input  logic           take
);
    import kmsd_pkg::*;

    logic  s1_valid_reg;
    item_t item_reg;
    logic  advance;

    // Stage moves when empty or when the core takes the held item
    assign advance    = !s1_valid_reg || take;
    assign in_stall   = !advance;
    assign item_out   = item_reg;
    assign item_valid = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_in;
        end
    end

endmodule

[src/kmsd_debounce_core.sv]
// Raw and stable key stores, shared settle counter and the result register.
// Depends on kmsd_pkg.
module kmsd_debounce_core #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  kmsd_pkg::item_t  item,
    input  logic             item_valid,
    output logic             take,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    output kmsd_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import kmsd_pkg::*;

    localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW   = $clog2(ROWS * COLS + 1);
    localparam int PADW = (COLS > 18) ? COLS : 18;

    logic [COLS-1:0]     raw_reg    [ROWS];
    logic [COLS-1:0]     raw_next   [ROWS];
    logic [COLS-1:0]     stable_reg [ROWS];
    logic [COLS-1:0]     stable_next[ROWS];
    logic [TW-1:0]       raw_total_reg, raw_total_next;
    logic [TW-1:0]       stable_total_reg, stable_total_next;
    logic [SETTLE_W-1:0] settle_scans_reg;
    logic [SETTLE_W-1:0] settle_left_reg, settle_left_next;
    logic                result_valid_reg;
    result_t             result_reg, result_next;

    logic            fire;
    logic            col_ok;
    logic [CW-1:0]   col_idx;
    logic            changed;
    logic [3:0]      ups, downs;
    logic            copy;
    logic            qrow_ok, qcol_ok;
    logic [COLS-1:0] row_sel;
    logic [PADW-1:0] row_pad;
    logic [8:0]      total_ext;

    assign take         = !result_valid_reg || !result_stall;
    assign fire         = item_valid && take;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign col_ok  = {1'b0, item.column} < 6'(COLS);
    assign col_idx = item.column[CW-1:0];

    // Raw store update: one column, every row; running count of raw keys
    always_comb
    begin
        logic was_bit;
        logic now_bit;
        changed = 1'b0;
        ups     = '0;
        downs   = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            raw_next[r] = raw_reg[r];
            was_bit     = raw_reg[r][col_idx];
            now_bit     = item.row_bits[r];
            if (item.op == OP_SAMPLE && col_ok && was_bit != now_bit)
            begin
                raw_next[r][col_idx] = now_bit;
                changed = 1'b1;
                if (now_bit)
                    ups = ups + 4'd1;
                else
                    downs = downs + 4'd1;
            end
        end
        raw_total_next = raw_total_reg + TW'(ups) - TW'(downs);
    end

    // Settle counter and copy into the stable store
    always_comb
    begin
        copy             = 1'b0;
        settle_left_next = settle_left_reg;
        if (item.op == OP_SAMPLE)
        begin
            if (changed)
                settle_left_next = settle_scans_reg;
        end
        else if (settle_left_reg != '0)
        begin
            settle_left_next = settle_left_reg - 8'd1;
            copy             = (settle_left_reg == 8'd1);
        end
        for (int r = 0; r < ROWS; r++)
        begin
            stable_next[r] = copy ? raw_reg[r] : stable_reg[r];
        end
        stable_total_next = copy ? raw_total_reg : stable_total_reg;
    end

    // Result from the state after this item
    assign qrow_ok   = {1'b0, item.query_row} < 4'(ROWS);
    assign qcol_ok   = {1'b0, item.query_column} < 6'(COLS);
    assign row_sel   = qrow_ok ? stable_next[item.query_row[RW-1:0]] : '0;
    assign row_pad   = PADW'(row_sel);
    assign total_ext = 9'(stable_total_next);

    always_comb
    begin
        result_next.settled    = (settle_left_next == '0);
        result_next.stable_row = row_pad[17:0];
        result_next.key_is_on  = qcol_ok && row_sel[item.query_column[CW-1:0]];
        result_next.key_count  = (total_ext > 9'd255) ? 8'hFF : total_ext[7:0];
        result_next.column_drive =
            (col_ok && item.column < 5'(DRIVE_ENTRIES)) ? drive_pattern(item.column) : 7'd0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                raw_reg[r]    <= '0;
                stable_reg[r] <= '0;
            end
            raw_total_reg    <= '0;
            stable_total_reg <= '0;
            settle_left_reg  <= '0;
            settle_scans_reg <= SETTLE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                settle_scans_reg <= cfg_wdata;
            if (take)
                result_valid_reg <= item_valid;
            if (fire)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    raw_reg[r]    <= raw_next[r];
                    stable_reg[r] <= stable_next[r];
                end
                raw_total_reg    <= raw_total_next;
                stable_total_reg <= stable_total_next;
                settle_left_reg  <= settle_left_next;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

endmodule

[src/key_matrix_scan_debounce.sv]
// Key matrix scanner with one shared debounce counter, top level.
// An accepted item passes the input reg, then the result reg, before its result is offered.
// One item per cycle unless out_stall holds; the single-pass core updates stores per item taken.
// Reset clears raw and stable stores, key counts and the settle counter; settle_scans
// returns to 5. Depends on kmsd_pkg, kmsd_in_stage and kmsd_debounce_core.
module key_matrix_scan_debounce #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [4:0]  column,
    input  logic [7:0]  row_bits,
    input  logic [2:0]  query_row,
    input  logic [4:0]  query_column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        settled,
    output logic [17:0] stable_row,
    output logic        key_is_on,
    output logic [7:0]  key_count,
    output logic [6:0]  column_drive,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import kmsd_pkg::*;

    item_t   item_in, item_s1;
    logic    item_s1_valid;
    logic    core_take;
    result_t result;

    assign item_in.op           = op_t'(op);
    assign item_in.column       = column;
    assign item_in.row_bits     = row_bits;
    assign item_in.query_row    = query_row;
    assign item_in.query_column = query_column;

    kmsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .item_out   (item_s1),
        .item_valid (item_s1_valid),
        .take       (core_take)
    );

    kmsd_debounce_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_s1),
        .item_valid   (item_s1_valid),
        .take         (core_take),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result       (result),
        .result_valid (out_valid),
        .result_stall (out_stall)
    );

    assign settled      = result.settled;
    assign stable_row   = result.stable_row;
    assign key_is_on    = result.key_is_on;
    assign key_count    = result.key_count;
    assign column_drive = result.column_drive;

endmodule

[src/kmsd_checker.sv]
// Port-level checks for the key matrix scanner, bound to the top level.
// Depends on kmsd_pkg and key_matrix_scan_debounce_defines.svh.
`include "key_matrix_scan_debounce_defines.svh"

module kmsd_checker #(
    parameter int ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int COLS = kmsd_pkg::COLS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        settled,
    input logic [17:0] stable_row,
    input logic        key_is_on,
    input logic [7:0]  key_count,
    input logic [6:0]  column_drive
);
    import kmsd_pkg::*;

    result_t out_fields;

    assign out_fields = {settled, stable_row, key_is_on, key_count, column_drive};

    // A stalled result stays offered
    `KMSD_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid)

    // A stalled result keeps its fields
    `KMSD_ASSERT_NEXT(a_out_payload_hold, out_valid && out_stall, $stable(out_fields))

    // Key bit comes from the reported row when the row is fully shown
    `KMSD_ASSERT_SAME(a_key_in_row, out_valid && stable_row == 18'd0, (COLS > 18) || !key_is_on)

    // An empty stable store shows no keys
    `KMSD_ASSERT_SAME(a_empty_store, out_valid && key_count == 8'd0, stable_row == 18'd0 && !key_is_on)

    // Count cannot exceed the matrix size
    `KMSD_ASSERT_SAME(a_count_bound, out_valid, 32'(key_count) <= ROWS * COLS)

endmodule

bind key_matrix_scan_debounce kmsd_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_kmsd_checker (.*);

[tb/key_matrix_scan_debounce_checker.sv]
`timescale 1ns / 1ps
// Checker for key_matrix_scan_debounce: watches the item, report and register ports,
// predicts each report from its own key stores and compares in order of arrival.
// Depends on kmsd_pkg for the op and report types.
module key_matrix_scan_debounce_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [4:0]  column,
    input  logic [7:0]  row_bits,
    input  logic [2:0]  query_row,
    input  logic [4:0]  query_column,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        settled,
    input  logic [17:0] stable_row,
    input  logic        key_is_on,
    input  logic [7:0]  key_count,
    input  logic [6:0]  column_drive,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import kmsd_pkg::*;

    localparam int NUM_ROWS = 8;
    localparam int NUM_COLS = 18;

    // Demux select pattern per column, column 0 in the low bits
    localparam logic [7*NUM_COLS-1:0] COL_SELECT = {
        7'h74, 7'h45, 7'h75, 7'h46, 7'h56, 7'h03, 7'h13, 7'h23, 7'h33,
        7'h43, 7'h53, 7'h63, 7'h73, 7'h07, 7'h17, 7'h44, 7'h54, 7'h64
    };

    logic [NUM_COLS-1:0] raw_keys    [NUM_ROWS];
    logic [NUM_COLS-1:0] stable_keys [NUM_ROWS];
    logic [7:0]          settle_left;
    logic [7:0]          settle_scans;
    result_t             expected_reports [$];
    int                  reports_seen;

    // Apply one item to the key stores and work out the report it gives
    task automatic debounce_predict(input op_t kind, input logic [4:0] col,
                                    input logic [7:0] rows, input logic [2:0] qrow,
                                    input logic [4:0] qcol, output result_t rep);
        int total;
        int r;
        total = 0;
        if (kind == OP_SAMPLE)
        begin
            // out-of-range columns leave the raw store alone
            if (col < NUM_COLS)
            begin
                for (r = 0; r < NUM_ROWS; r++)
                begin
                    if (raw_keys[r][col] != rows[r])
                    begin
                        raw_keys[r][col] = rows[r];
                        settle_left = settle_scans;
                    end
                end
            end
        end
        else if (settle_left != 8'd0)
        begin
            settle_left = settle_left - 8'd1;
            if (settle_left == 8'd0)
            begin
                for (r = 0; r < NUM_ROWS; r++)
                    stable_keys[r] = raw_keys[r];
            end
        end

        for (r = 0; r < NUM_ROWS; r++)
            total += $countones(stable_keys[r]);

        rep.settled    = (settle_left == 8'd0);
        rep.stable_row = stable_keys[qrow];
        if (qcol < NUM_COLS)
            rep.key_is_on = stable_keys[qrow][qcol];
        else
            rep.key_is_on = 1'b0;
        rep.key_count = (total > 255) ? 8'd255 : total[7:0];
        if (col < NUM_COLS)
            rep.column_drive = COL_SELECT[col*7 +: 7];
        else
            rep.column_drive = 7'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        int r;
        if (!rst_n)
        begin
            for (r = 0; r < NUM_ROWS; r++)
            begin
                raw_keys[r]    = '0;
                stable_keys[r] = '0;
            end
            settle_left  = 8'd0;
            settle_scans = SETTLE_RESET;
            expected_reports.delete();
            reports_seen = 0;
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            // report side first; an item taken on this edge cannot have its report yet
            if (out_valid && !out_stall)
            begin
                got = {settled, stable_row, key_is_on, key_count, column_drive};
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("report %0d arrived with none outstanding: settled=%0d row=%05h key=%0d count=%0d drive=%02h",
                                 reports_seen, got.settled, got.stable_row, got.key_is_on,
                                 got.key_count, got.column_drive);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.settled !== want.settled || got.stable_row !== want.stable_row ||
                        got.key_is_on !== want.key_is_on || got.key_count !== want.key_count ||
                        got.column_drive !== want.column_drive)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("report %0d mismatch at %0t", reports_seen, $realtime);
                            $display("  expected settled=%0d row=%05h key=%0d count=%0d drive=%02h",
                                     want.settled, want.stable_row, want.key_is_on,
                                     want.key_count, want.column_drive);
                            $display("  actual   settled=%0d row=%05h key=%0d count=%0d drive=%02h",
                                     got.settled, got.stable_row, got.key_is_on,
                                     got.key_count, got.column_drive);
                        end
                    end
                end
            end

            // item side
            if (in_valid && !in_stall)
            begin
                debounce_predict((op == 1'b1) ? OP_END_SCAN : OP_SAMPLE, column, row_bits,
                                 query_row, query_column, want);
                expected_reports.push_back(want);
            end

            if (cfg_we)
                settle_scans = cfg_wdata;

            pending = expected_reports.size();
        end
    end

endmodule

[tb/key_matrix_scan_debounce_tb.sv]
`timescale 1ns / 1ps
// Top of the key_matrix_scan_debounce testbench: clock, reset, item and stall stimulus
// and the verdict. Depends on kmsd_pkg, the block and key_matrix_scan_debounce_checker.
module key_matrix_scan_debounce_tb;
    import kmsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [4:0]  column;
    logic [7:0]  row_bits;
    logic [2:0]  query_row;
    logic [4:0]  query_column;
    logic        out_valid;
    logic        out_stall;
    logic        settled;
    logic [17:0] stable_row;
    logic        key_is_on;
    logic [7:0]  key_count;
    logic [6:0]  column_drive;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_stall_pct;

    // keys as physically held down, one column vector per row
    logic [17:0] held_keys [8];

    key_matrix_scan_debounce uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .column       (column),
        .row_bits     (row_bits),
        .query_row    (query_row),
        .query_column (query_column),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .settled      (settled),
        .stable_row   (stable_row),
        .key_is_on    (key_is_on),
        .key_count    (key_count),
        .column_drive (column_drive),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    key_matrix_scan_debounce_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .column       (column),
        .row_bits     (row_bits),
        .query_row    (query_row),
        .query_column (query_column),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .settled      (settled),
        .stable_row   (stable_row),
        .key_is_on    (key_is_on),
        .key_count    (key_count),
        .column_drive (column_drive),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // Report-side back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item, with random idle cycles ahead of it; returns on the edge it is taken
    task automatic send_item(input op_t kind, input logic [4:0] col, input logic [7:0] rows,
                             input logic [2:0] qrow, input logic [4:0] qcol);
        logic taken;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= kind;
        column       <= col;
        row_bits     <= rows;
        query_row    <= qrow;
        query_column <= qcol;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    // Hold off until every report has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_settle(input logic [7:0] scans);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= scans;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Query mostly inside the matrix, sometimes past the last column
    task automatic pick_query(output logic [2:0] qrow, output logic [4:0] qcol);
        qrow = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            qcol = 5'($urandom_range(18, 31));
        else
            qcol = 5'($urandom_range(0, 17));
    endtask

    task automatic send_end_scan();
        logic [2:0] qrow;
        logic [4:0] qcol;
        logic [4:0] col;
        logic [7:0] rows;
        pick_query(qrow, qcol);
        col  = 5'($urandom_range(0, 31));
        rows = 8'($urandom_range(0, 255));
        send_item(OP_END_SCAN, col, rows, qrow, qcol);
    endtask

    // Fully random item, any op and any column
    task automatic send_noise();
        op_t        kind;
        logic [4:0] col;
        logic [7:0] rows;
        logic [2:0] qrow;
        logic [4:0] qcol;
        kind = ($urandom_range(0, 1) == 0) ? OP_SAMPLE : OP_END_SCAN;
        col  = 5'($urandom_range(0, 31));
        rows = 8'($urandom_range(0, 255));
        qrow = 3'($urandom_range(0, 7));
        qcol = 5'($urandom_range(0, 31));
        send_item(kind, col, rows, qrow, qcol);
    endtask

    // Press or release some keys; now and then the whole matrix at once
    task automatic change_keys();
        int pick;
        int r;
        int c;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            for (r = 0; r < 8; r++)
                held_keys[r] = '1;
        end
        else if (pick == 1)
        begin
            for (r = 0; r < 8; r++)
                held_keys[r] = '0;
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                r = $urandom_range(0, 7);
                c = $urandom_range(0, 17);
                held_keys[r][c] = ~held_keys[r][c];
            end
        end
    endtask

    // One full scan: every column in order, then the end-of-scan item
    task automatic scan_matrix(input bit bouncy);
        int         col;
        int         r;
        logic [7:0] rows;
        logic [2:0] qrow;
        logic [4:0] qcol;
        for (col = 0; col < 18; col++)
        begin
            for (r = 0; r < 8; r++)
                rows[r] = held_keys[r][col];
            // contact bounce flips one row reading
            if (bouncy && $urandom_range(0, 9) == 0)
            begin
                r = $urandom_range(0, 7);
                rows[r] = ~rows[r];
            end
            pick_query(qrow, qcol);
            send_item(OP_SAMPLE, col[4:0], rows, qrow, qcol);
        end
        send_end_scan();
    endtask

    task automatic run_scans(input int scans);
        repeat (scans)
        begin
            if ($urandom_range(0, 3) == 0)
                change_keys();
            scan_matrix($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_noise();
            end
        end
    endtask

    initial
    begin
        int r;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = 1'b0;
        column       = '0;
        row_bits     = '0;
        query_row    = '0;
        query_column = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        cycle_count  = 0;
        tx_idle_pct  = 25;
        rx_stall_pct = 25;
        for (r = 0; r < 8; r++)
            held_keys[r] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, settle count at its reset value of five
        send_item(OP_END_SCAN, 5'd31, 8'hFF, 3'd7, 5'd31);   // counter already zero
        send_item(OP_SAMPLE, 5'd31, 8'hFF, 3'd0, 5'd0);      // column past the matrix
        send_item(OP_SAMPLE, 5'd18, 8'hAA, 3'd0, 5'd18);     // first column without a drive
        send_item(OP_SAMPLE, 5'd0, 8'hFF, 3'd0, 5'd0);
        send_item(OP_SAMPLE, 5'd17, 8'h81, 3'd7, 5'd17);
        send_item(OP_SAMPLE, 5'd17, 8'h81, 3'd7, 5'd17);     // no change, no reload
        send_item(OP_END_SCAN, 5'd0, 8'h00, 3'd0, 5'd0);
        send_item(OP_END_SCAN, 5'd17, 8'hFF, 3'd7, 5'd17);
        send_item(OP_END_SCAN, 5'd5, 8'h55, 3'd3, 5'd18);
        send_item(OP_END_SCAN, 5'd12, 8'hAA, 3'd7, 5'd0);
        send_item(OP_END_SCAN, 5'd31, 8'hFF, 3'd0, 5'd0);    // copy to stable store
        send_item(OP_END_SCAN, 5'd3, 8'h00, 3'd7, 5'd17);    // stays at zero
        send_item(OP_SAMPLE, 5'd0, 8'h00, 3'd0, 5'd31);      // release column 0
        send_item(OP_END_SCAN, 5'd13, 8'h0F, 3'd1, 5'd0);

        // Fastest settle, no idling on either side
        write_settle(8'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (r = 0; r < 8; r++)
            held_keys[r] = '1;
        run_scans(8);
        tx_idle_pct  = 25;
        rx_stall_pct = 25;

        // Slowest settle: one change, then a full run of end-of-scan items
        write_settle(8'd255);
        held_keys[0][0] = ~held_keys[0][0];
        change_keys();
        scan_matrix(1'b0);
        repeat (255)
            send_end_scan();

        // Mid-range settle counts with bouncing keys
        write_settle(8'($urandom_range(2, 12)));
        run_scans(9);
        write_settle(8'($urandom_range(2, 12)));
        run_scans(4);
        wait_drained();
        run_scans(5);
        write_settle(8'($urandom_range(2, 12)));
        run_scans(9);

        wait_drained();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
